>>> hdl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared constants, types and the arctangent table for the rectangular /
// polar CORDIC converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

  // default configuration
  localparam int ITERATIONS_DEF  = 16;
  localparam int COORD_WIDTH_DEF = 24;
  localparam int MAX_ITERATIONS  = 24;

  // extra fraction bits carried through the datapath
  localparam int GUARD = 6;

  // angle accumulator, 2^32 per turn
  localparam int ANGLE_W = 32;
  // output angle, 2^16 per turn
  localparam int BAM_W = 16;

  // 1/K in 0.32 fixed point
  localparam logic [31:0] INV_GAIN = 32'd2608131496;
  localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 32'sh4000_0000;
  localparam logic [BAM_W-1:0] BAM_HALF_TURN = 16'h8000;
  localparam logic [ANGLE_W-1:0] BAM_ROUND = 32'h0000_8000;

  // action codes on the input
  localparam logic [1:0] ACT_RECT  = 2'd0;
  localparam logic [1:0] ACT_POLAR = 2'd1;

  // decoded form of an item
  typedef enum logic [1:0] {
    FORM_RECT  = 2'd0,
    FORM_POLAR = 2'd1,
    FORM_BAD   = 2'd2
  } form_t;

  // per-item control carried alongside the datapath
  typedef struct packed {
    form_t form;
    logic  zero_vec;
  } ctl_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [ANGLE_W-1:0] atan_angle(input int idx);
    logic [ANGLE_W-1:0] res;
    case (idx)
      0:       res = 32'h2000_0000;
      1:       res = 32'h12E4_051E;
      2:       res = 32'h09FB_385B;
      3:       res = 32'h0511_11D4;
      4:       res = 32'h028B_0D43;
      5:       res = 32'h0145_D7E1;
      6:       res = 32'h00A2_F61E;
      7:       res = 32'h0051_7C55;
      8:       res = 32'h0028_BE53;
      9:       res = 32'h0014_5F2F;
      10:      res = 32'h000A_2F98;
      11:      res = 32'h0005_17CC;
      12:      res = 32'h0002_8BE6;
      13:      res = 32'h0001_45F3;
      14:      res = 32'h0000_A2FA;
      15:      res = 32'h0000_517D;
      16:      res = 32'h0000_28BE;
      17:      res = 32'h0000_145F;
      18:      res = 32'h0000_0A30;
      19:      res = 32'h0000_0518;
      20:      res = 32'h0000_028C;
      21:      res = 32'h0000_0146;
      22:      res = 32'h0000_00A3;
      23:      res = 32'h0000_0051;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rpc_prep.sv
// ----------------------------------------------------------------------------
// rpc_prep
// Entry stage: decodes the form, folds the vector or angle into the right
// half plane and pre-scales a polar magnitude by 1/K.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_prep import rpc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IW = COORD_WIDTH + GUARD + 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic signed [COORD_WIDTH-1:0] first,
  input  logic signed [COORD_WIDTH-1:0] second,
  input  logic                          ready_down,
  output logic                          valid,
  output ctl_t                          ctl,
  output logic signed [IW-1:0]          x,
  output logic signed [IW-1:0]          y,
  output logic [ANGLE_W-1:0]            z,
  output logic signed [COORD_WIDTH-1:0] first_q,
  output logic signed [COORD_WIDTH-1:0] second_q
);

  localparam int MW = COORD_WIDTH + GUARD;
  localparam int PW = MW + 32;

  logic                     ready_up;
  ctl_t                     ctl_next;
  logic signed [IW-1:0]     a_ext;
  logic signed [IW-1:0]     a_sh;
  logic signed [IW-1:0]     b_sh;
  logic signed [IW-1:0]     x_rect;
  logic signed [IW-1:0]     y_rect;
  logic [ANGLE_W-1:0]       z_rect;
  logic [ANGLE_W-1:0]       sec32;
  logic [ANGLE_W-1:0]       turn;
  logic signed [ANGLE_W-1:0] turn_s;
  logic                     fold;
  logic [ANGLE_W-1:0]       z_polar;
  logic signed [IW-1:0]     mag;
  logic                     mag_neg;
  logic [IW-1:0]            mag_abs;
  logic [MW-1:0]            mag_scaled;
  logic [PW-1:0]            prod;
  logic [PW-1:0]            prod_rnd;
  logic [MW-1:0]            gain_mag;
  logic signed [IW-1:0]     x_polar;

  assign ready_up = !valid || ready_down;
  assign in_stall = !ready_up;

  // form decode
  always_comb begin
    ctl_next.zero_vec = (first == '0) && (second == '0);
    case (action)
      ACT_RECT:  ctl_next.form = FORM_RECT;
      ACT_POLAR: ctl_next.form = FORM_POLAR;
      default:   ctl_next.form = FORM_BAD;
    endcase
  end

  // rectangular: add guard bits, fold a left-half vector by a half turn
  assign a_ext = IW'(first);
  assign a_sh  = a_ext <<< GUARD;
  assign b_sh  = IW'(second) <<< GUARD;

  always_comb begin
    if (first[COORD_WIDTH-1]) begin
      x_rect = -a_sh;
      y_rect = -b_sh;
      z_rect = HALF_TURN;
    end else begin
      x_rect = a_sh;
      y_rect = b_sh;
      z_rect = '0;
    end
  end

  // polar: low 16 bits of the angle, folded into +/- quarter turn
  assign sec32   = ANGLE_W'(second);
  assign turn    = {sec32[BAM_W-1:0], {(ANGLE_W-BAM_W){1'b0}}};
  assign turn_s  = turn;
  assign fold    = (turn_s > QUARTER_TURN) || (turn_s < -QUARTER_TURN);
  assign z_polar = fold ? (turn ^ HALF_TURN) : turn;
  assign mag     = fold ? -a_ext : a_ext;

  // polar: start magnitude times 1/K, rounded half away from zero
  assign mag_neg    = mag[IW-1];
  assign mag_abs    = mag_neg ? IW'(-mag) : IW'(mag);
  assign mag_scaled = MW'(mag_abs << GUARD);
  assign prod       = PW'(mag_scaled) * PW'(INV_GAIN);
  assign prod_rnd   = prod + (PW'(1) << 31);
  assign gain_mag   = prod_rnd[PW-1:32];
  assign x_polar    = mag_neg ? -IW'(gain_mag) : IW'(gain_mag);

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      ctl      <= ctl_next;
      first_q  <= first;
      second_q <= second;
      if (ctl_next.form == FORM_POLAR) begin
        x <= x_polar;
        y <= '0;
        z <= z_polar;
      end else begin
        x <= x_rect;
        y <= y_rect;
        z <= z_rect;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rpc_cordic_stage.sv
// ----------------------------------------------------------------------------
// rpc_cordic_stage
// One registered CORDIC micro-rotation. Vectoring steers by the sign of y,
// rotation steers by the sign of the residual angle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_cordic_stage import rpc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int IDX = 0,
  localparam int IW = COORD_WIDTH + GUARD + 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  output logic                          ready_up,
  input  ctl_t                          ctl_in,
  input  logic signed [IW-1:0]          x_in,
  input  logic signed [IW-1:0]          y_in,
  input  logic [ANGLE_W-1:0]            z_in,
  input  logic signed [COORD_WIDTH-1:0] first_in,
  input  logic signed [COORD_WIDTH-1:0] second_in,
  input  logic                          ready_down,
  output logic                          valid,
  output ctl_t                          ctl,
  output logic signed [IW-1:0]          x,
  output logic signed [IW-1:0]          y,
  output logic [ANGLE_W-1:0]            z,
  output logic signed [COORD_WIDTH-1:0] first_q,
  output logic signed [COORD_WIDTH-1:0] second_q
);

  localparam logic [ANGLE_W-1:0] ATAN = atan_angle(IDX);

  logic                 ccw;
  logic signed [IW-1:0] dx;
  logic signed [IW-1:0] dy;

  assign ready_up = !valid || ready_down;

  // rotation direction
  assign ccw = (ctl_in.form == FORM_RECT) ? y_in[IW-1] : !z_in[ANGLE_W-1];
  assign dx  = y_in >>> IDX;
  assign dy  = x_in >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      ctl      <= ctl_in;
      first_q  <= first_in;
      second_q <= second_in;
      if (ccw) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - ATAN;
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + ATAN;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rpc_gain.sv
// ----------------------------------------------------------------------------
// rpc_gain
// Removes the CORDIC gain from the vectoring result: x times 1/K, rounded
// half away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_gain import rpc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IW = COORD_WIDTH + GUARD + 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  output logic                          ready_up,
  input  ctl_t                          ctl_in,
  input  logic signed [IW-1:0]          x_in,
  input  logic signed [IW-1:0]          y_in,
  input  logic [ANGLE_W-1:0]            z_in,
  input  logic signed [COORD_WIDTH-1:0] first_in,
  input  logic signed [COORD_WIDTH-1:0] second_in,
  input  logic                          ready_down,
  output logic                          valid,
  output ctl_t                          ctl,
  output logic signed [IW-1:0]          x,
  output logic signed [IW-1:0]          y,
  output logic [ANGLE_W-1:0]            z,
  output logic signed [IW-1:0]          mag,
  output logic signed [COORD_WIDTH-1:0] first_q,
  output logic signed [COORD_WIDTH-1:0] second_q
);

  localparam int PW = IW + 32;

  logic          x_neg;
  logic [IW-1:0] x_abs;
  logic [PW-1:0] prod;
  logic [PW-1:0] prod_rnd;
  logic [IW-1:0] gain_mag;

  assign ready_up = !valid || ready_down;

  // sign-magnitude multiply by 1/K
  assign x_neg    = x_in[IW-1];
  assign x_abs    = x_neg ? IW'(-x_in) : IW'(x_in);
  assign prod     = PW'(x_abs) * PW'(INV_GAIN);
  assign prod_rnd = prod + (PW'(1) << 31);
  assign gain_mag = prod_rnd[PW-1:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      ctl      <= ctl_in;
      x        <= x_in;
      y        <= y_in;
      z        <= z_in;
      first_q  <= first_in;
      second_q <= second_in;
      mag      <= x_neg ? -$signed(gain_mag) : $signed(gain_mag);
    end
  end

endmodule

`default_nettype wire

>>> hdl/rpc_out.sv
// ----------------------------------------------------------------------------
// rpc_out
// Output register: drops guard bits, saturates, rounds the angle and
// assembles the four coordinates for each form.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_out import rpc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IW = COORD_WIDTH + GUARD + 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  output logic                          ready_up,
  input  ctl_t                          ctl_in,
  input  logic signed [IW-1:0]          x_in,
  input  logic signed [IW-1:0]          y_in,
  input  logic [ANGLE_W-1:0]            z_in,
  input  logic signed [IW-1:0]          mag_in,
  input  logic signed [COORD_WIDTH-1:0] first_in,
  input  logic signed [COORD_WIDTH-1:0] second_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] x_out,
  output logic signed [COORD_WIDTH-1:0] y_out,
  output logic [COORD_WIDTH-1:0]        magnitude,
  output logic signed [BAM_W-1:0]       angle_out,
  output logic                          bad_form
);

  localparam int RW = IW - GUARD;
  localparam logic signed [RW-1:0] MAG_MAX = RW'((64'd1 << COORD_WIDTH) - 64'd1);
  localparam logic signed [RW-1:0] CRD_MAX = RW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic signed [RW-1:0] CRD_MIN = -CRD_MAX - RW'(1);
  localparam logic signed [IW-1:0] HALF_LSB = IW'(1) <<< (GUARD - 1);

  logic signed [IW-1:0]          x_sum;
  logic signed [IW-1:0]          y_sum;
  logic signed [IW-1:0]          m_sum;
  logic signed [RW-1:0]          x_rnd;
  logic signed [RW-1:0]          y_rnd;
  logic signed [RW-1:0]          m_rnd;
  logic signed [COORD_WIDTH-1:0] x_sat;
  logic signed [COORD_WIDTH-1:0] y_sat;
  logic [COORD_WIDTH-1:0]        m_sat;
  logic [ANGLE_W-1:0]            z_rnd;
  logic [ANGLE_W-1:0]            sec32;
  logic [BAM_W-1:0]              ang;
  logic                          first_neg;
  logic signed [COORD_WIDTH-1:0] x_next;
  logic signed [COORD_WIDTH-1:0] y_next;
  logic [COORD_WIDTH-1:0]        mag_next;
  logic [BAM_W-1:0]              ang_next;

  assign ready_up = !out_valid || !out_stall;

  // round half up and drop guard bits
  assign x_sum = x_in + HALF_LSB;
  assign y_sum = y_in + HALF_LSB;
  assign m_sum = mag_in + HALF_LSB;
  assign x_rnd = RW'(x_sum >>> GUARD);
  assign y_rnd = RW'(y_sum >>> GUARD);
  assign m_rnd = RW'(m_sum >>> GUARD);

  // saturation
  always_comb begin
    if (x_rnd > CRD_MAX) begin
      x_sat = COORD_WIDTH'(CRD_MAX);
    end else if (x_rnd < CRD_MIN) begin
      x_sat = COORD_WIDTH'(CRD_MIN);
    end else begin
      x_sat = COORD_WIDTH'(x_rnd);
    end
    if (y_rnd > CRD_MAX) begin
      y_sat = COORD_WIDTH'(CRD_MAX);
    end else if (y_rnd < CRD_MIN) begin
      y_sat = COORD_WIDTH'(CRD_MIN);
    end else begin
      y_sat = COORD_WIDTH'(y_rnd);
    end
    if (m_rnd[RW-1]) begin
      m_sat = '0;
    end else if (m_rnd > MAG_MAX) begin
      m_sat = COORD_WIDTH'(MAG_MAX);
    end else begin
      m_sat = COORD_WIDTH'(m_rnd);
    end
  end

  // angle rounding and the polar pass-through angle
  assign z_rnd     = z_in + BAM_ROUND;
  assign sec32     = ANGLE_W'(second_in);
  assign ang       = sec32[BAM_W-1:0];
  assign first_neg = first_in[COORD_WIDTH-1];

  // result assembly per form
  always_comb begin
    case (ctl_in.form)
      FORM_RECT: begin
        x_next   = first_in;
        y_next   = second_in;
        mag_next = m_sat;
        ang_next = ctl_in.zero_vec ? '0 : z_rnd[ANGLE_W-1:ANGLE_W-BAM_W];
      end
      FORM_POLAR: begin
        x_next   = x_sat;
        y_next   = y_sat;
        mag_next = first_neg ? COORD_WIDTH'(-first_in) : COORD_WIDTH'(first_in);
        ang_next = first_neg ? (ang + BAM_HALF_TURN) : ang;
      end
      default: begin
        x_next   = '0;
        y_next   = '0;
        mag_next = '0;
        ang_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_up) begin
      out_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      x_out     <= x_next;
      y_out     <= y_next;
      magnitude <= mag_next;
      angle_out <= ang_next;
      bad_form  <= (ctl_in.form != FORM_RECT) && (ctl_in.form != FORM_POLAR);
    end
  end

endmodule

`default_nettype wire

>>> hdl/rect_polar_converter_core.sv
// Registers from input acceptance to out_valid, in order:
//   entry stage, one register per CORDIC iteration, gain multiply, output.
// Throughput: one item per cycle while the output is not stalled; each stage holds one
//   item and advances whenever its successor is empty or moving.
// Reset (rst, synchronous): clears all stage valid flags; no other state.
// ----------------------------------------------------------------------------
// rect_polar_converter_core
// Unrolled CORDIC converting 2-D vectors between rectangular (Q12.12) and
// polar (binary angle) form.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_polar_converter_core import rpc_pkg::*; #(
  parameter int ITERATIONS  = ITERATIONS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic signed [COORD_WIDTH-1:0] first,
  input  logic signed [COORD_WIDTH-1:0] second,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] x_out,
  output logic signed [COORD_WIDTH-1:0] y_out,
  output logic [COORD_WIDTH-1:0]        magnitude,
  output logic signed [BAM_W-1:0]       angle_out,
  output logic                          bad_form
);

  localparam int IW = COORD_WIDTH + GUARD + 3;

  // pipeline links, index k feeds CORDIC stage k
  logic                          vld   [ITERATIONS+1];
  logic                          rdy   [ITERATIONS+1];
  ctl_t                          ctl_s [ITERATIONS+1];
  logic signed [IW-1:0]          xs    [ITERATIONS+1];
  logic signed [IW-1:0]          ys    [ITERATIONS+1];
  logic [ANGLE_W-1:0]            zs    [ITERATIONS+1];
  logic signed [COORD_WIDTH-1:0] fs    [ITERATIONS+1];
  logic signed [COORD_WIDTH-1:0] ss    [ITERATIONS+1];

  logic                          g_valid;
  logic                          g_ready;
  logic                          o_ready;
  ctl_t                          g_ctl;
  logic signed [IW-1:0]          g_x;
  logic signed [IW-1:0]          g_y;
  logic [ANGLE_W-1:0]            g_z;
  logic signed [IW-1:0]          g_mag;
  logic signed [COORD_WIDTH-1:0] g_first;
  logic signed [COORD_WIDTH-1:0] g_second;

  // entry stage
  rpc_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .first     (first),
    .second    (second),
    .ready_down(rdy[0]),
    .valid     (vld[0]),
    .ctl       (ctl_s[0]),
    .x         (xs[0]),
    .y         (ys[0]),
    .z         (zs[0]),
    .first_q   (fs[0]),
    .second_q  (ss[0])
  );

  // micro-rotation chain
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
    rpc_cordic_stage #(.COORD_WIDTH(COORD_WIDTH), .IDX(k)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (vld[k]),
      .ready_up  (rdy[k]),
      .ctl_in    (ctl_s[k]),
      .x_in      (xs[k]),
      .y_in      (ys[k]),
      .z_in      (zs[k]),
      .first_in  (fs[k]),
      .second_in (ss[k]),
      .ready_down(rdy[k+1]),
      .valid     (vld[k+1]),
      .ctl       (ctl_s[k+1]),
      .x         (xs[k+1]),
      .y         (ys[k+1]),
      .z         (zs[k+1]),
      .first_q   (fs[k+1]),
      .second_q  (ss[k+1])
    );
  end

  // gain correction
  rpc_gain #(.COORD_WIDTH(COORD_WIDTH)) u_gain (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (vld[ITERATIONS]),
    .ready_up  (g_ready),
    .ctl_in    (ctl_s[ITERATIONS]),
    .x_in      (xs[ITERATIONS]),
    .y_in      (ys[ITERATIONS]),
    .z_in      (zs[ITERATIONS]),
    .first_in  (fs[ITERATIONS]),
    .second_in (ss[ITERATIONS]),
    .ready_down(o_ready),
    .valid     (g_valid),
    .ctl       (g_ctl),
    .x         (g_x),
    .y         (g_y),
    .z         (g_z),
    .mag       (g_mag),
    .first_q   (g_first),
    .second_q  (g_second)
  );

  assign rdy[ITERATIONS] = g_ready;

  // output register
  rpc_out #(.COORD_WIDTH(COORD_WIDTH)) u_out (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (g_valid),
    .ready_up  (o_ready),
    .ctl_in    (g_ctl),
    .x_in      (g_x),
    .y_in      (g_y),
    .z_in      (g_z),
    .mag_in    (g_mag),
    .first_in  (g_first),
    .second_in (g_second),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_out     (x_out),
    .y_out     (y_out),
    .magnitude (magnitude),
    .angle_out (angle_out),
    .bad_form  (bad_form)
  );

`ifndef SYNTHESIS
  // an invalid form yields an all-zero result
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_form |-> (x_out == '0) && (y_out == '0) &&
                              (magnitude == '0) && (angle_out == '0))
    else $error("invalid-form item with nonzero coordinates");

  // the input only backs up when the whole pipe is full behind a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && vld[0] && g_valid)
    else $error("input stalled while the pipeline has room");

  // an accepted item lands in the entry stage
  a_entry_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted item missing from entry stage");
`endif

endmodule

`default_nettype wire
